/* rtl/core/lfu_pkg.sv */
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the incoming beat
		logic scan;    // step the scan over one entry
		logic commit;  // apply the update and drive the result
	} lfu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} lfu_sts_t;

endpackage

/* rtl/core/lfu_ctrl.sv */
module lfu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output lfu_pkg::lfu_cmd_t cmd,
	input  lfu_pkg::lfu_sts_t sts
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/lfu_dpath.sv */
module lfu_dpath #(
	parameter int ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfu_pkg::lfu_cmd_t            cmd,
	output lfu_pkg::lfu_sts_t            sts,
	input  logic [lfu_pkg::CAP_W-1:0]    cap_q,
	input  logic                         operation,
	input  logic signed [lfu_pkg::KEY_W-1:0] key,
	input  logic signed [lfu_pkg::VAL_W-1:0] value,
	output logic                         done,
	output logic                         found,
	output logic signed [lfu_pkg::VAL_W-1:0] read_value,
	output logic                         evicted,
	output logic signed [lfu_pkg::KEY_W-1:0] evicted_key
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

	logic [ENTRIES-1:0]               valid_q;
	logic [lfu_pkg::KEY_W-1:0]        key_mem   [ENTRIES];
	logic [lfu_pkg::VAL_W-1:0]        value_mem [ENTRIES];
	logic [lfu_pkg::CNT_W-1:0]        count_mem [ENTRIES];
	logic [lfu_pkg::STAMP_W-1:0]      stamp_mem [ENTRIES];
	logic [lfu_pkg::STAMP_W-1:0]      seq_q;

	logic                             op_q;
	logic [lfu_pkg::KEY_W-1:0]        key_q;
	logic [lfu_pkg::VAL_W-1:0]        val_q;

	logic [IDX_W-1:0]                 idx_q;
	logic                             hit_q;
	logic [IDX_W-1:0]                 hit_idx_q;
	logic                             free_q;
	logic [IDX_W-1:0]                 free_idx_q;
	logic                             vic_q;
	logic [IDX_W-1:0]                 vic_idx_q;
	logic [lfu_pkg::CNT_W-1:0]        vic_cnt_q;
	logic [lfu_pkg::STAMP_W-1:0]      vic_stamp_q;
	logic [lfu_pkg::KEY_W-1:0]        vic_key_q;
	logic [lfu_pkg::VAL_W-1:0]        hit_val_q;
	logic [lfu_pkg::CNT_W-1:0]        hit_cnt_q;
	logic [OCC_W-1:0]                 used_q;

	logic                             e_valid;
	logic [lfu_pkg::KEY_W-1:0]        e_key;
	logic [lfu_pkg::CNT_W-1:0]        e_cnt;
	logic [lfu_pkg::STAMP_W-1:0]      e_stamp;
	logic                             e_better;
	logic [CMP_W-1:0]                 cap_eff;
	logic [CMP_W-1:0]                 used_ext;
	logic                             do_bump;
	logic                             do_evict;
	logic                             do_insert;
	logic [IDX_W-1:0]                 ins_idx;

	assign e_valid  = valid_q[idx_q];
	assign e_key    = key_mem[idx_q];
	assign e_cnt    = count_mem[idx_q];
	assign e_stamp  = stamp_mem[idx_q];
	assign e_better = !vic_q || (e_cnt < vic_cnt_q) ||
		((e_cnt == vic_cnt_q) && (e_stamp < vic_stamp_q));
	assign sts.scan_done = (idx_q == IDX_W'(ENTRIES - 1));

	always_comb begin
		if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end
	assign used_ext = CMP_W'(used_q);

	assign do_bump   = cmd.commit && hit_q && (hit_cnt_q != '1) &&
		((op_q == lfu_pkg::OP_GET) || (cap_q != '0));
	assign do_evict  = cmd.commit && (op_q == lfu_pkg::OP_PUT) && (cap_q != '0) &&
		!hit_q && (used_ext >= cap_eff) && vic_q;
	assign do_insert = cmd.commit && (op_q == lfu_pkg::OP_PUT) && (cap_q != '0) &&
		!hit_q && (do_evict || free_q);
	assign ins_idx   = do_evict ? vic_idx_q : free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seq_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (do_bump || do_insert) begin
				seq_q <= seq_q + 1'b1;
			end
			if (do_insert) begin
				valid_q[ins_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			key_q  <= key;
			val_q  <= value;
			idx_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
			used_q <= '0;
		end
		if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (e_valid) begin
				used_q <= used_q + 1'b1;
				if (!hit_q && (e_key == key_q)) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_q;
					hit_val_q <= value_mem[idx_q];
					hit_cnt_q <= e_cnt;
				end
				if (e_better) begin
					vic_q       <= 1'b1;
					vic_idx_q   <= idx_q;
					vic_cnt_q   <= e_cnt;
					vic_stamp_q <= e_stamp;
					vic_key_q   <= e_key;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (do_bump) begin
			count_mem[hit_idx_q] <= hit_cnt_q + 1'b1;
			stamp_mem[hit_idx_q] <= seq_q;
		end
		if (cmd.commit && hit_q && (op_q == lfu_pkg::OP_PUT) && (cap_q != '0)) begin
			value_mem[hit_idx_q] <= val_q;
		end
		if (do_insert) begin
			key_mem[ins_idx]   <= key_q;
			value_mem[ins_idx] <= val_q;
			count_mem[ins_idx] <= lfu_pkg::CNT_W'(1);
			stamp_mem[ins_idx] <= seq_q;
		end
		if (cmd.commit) begin
			found       <= hit_q;
			read_value  <= (hit_q && (op_q == lfu_pkg::OP_GET)) ? hit_val_q : '1;
			evicted     <= do_evict;
			evicted_key <= do_evict ? vic_key_q : '0;
		end
	end

endmodule

/* rtl/core/lfu_cache_policy.sv */
// Sequence: the start beat is accepted while idle and loaded, the scan visits one
// entry a cycle until it has seen every entry, then the commit applies the update,
// and the registered result shows with the done strobe. No new beat is taken while
// busy, so each beat is through its commit before the next one is accepted.
// Reset (arst_n low) clears all valid bits, the sequence counter and the
// controller; capacity returns to 16. The receiver cannot stall the result.
module lfu_cache_policy #(
	parameter int ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  value,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                              done,
	output logic                              found,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);

	// Capacity register; values above ENTRIES are clamped in the datapath.
	logic [lfu_pkg::CAP_W-1:0] cap_q;
	lfu_pkg::lfu_cmd_t         cmd;
	lfu_pkg::lfu_sts_t         sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_W'(16);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// The controller sequences load, a scan of every entry that finds the
	// hit, the first free slot, the occupancy and the LFU victim (oldest
	// stamp among the lowest count), then the commit.
	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	lfu_dpath #(
		.ENTRIES(ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cap_q       (cap_q),
		.operation   (operation),
		.key         (key),
		.value       (value),
		.done        (done),
		.found       (found),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	// A result beat only follows a commit, which happens while busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a busy cycle before it");

	// At most one of the commands is active at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.commit}))
		else $error("controller issued overlapping commands");

	// An eviction is only reported together with a miss.
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> !found)
		else $error("eviction reported on a hit");

	// Accepting a beat raises busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the block busy");

endmodule
